[design/cfsr_pkg.sv]
package cfsr_pkg;

  typedef enum logic [2:0] {
    OP_PUSH    = 3'd0,
    OP_POP     = 3'd1,
    OP_CLEAR   = 3'd2,
    OP_REVERSE = 3'd3,
    OP_FIND    = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_REV_RD,
    S_REV_WA,
    S_REV_WB,
    S_FIND_RD,
    S_FIND_CMP,
    S_FRONT,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic    accept;
    logic    push;
    logic    pop;
    logic    clear;
    logic    rev_init;
    logic    rev_step;
    logic    find_init;
    logic    find_step;
    logic    find_hit;
    logic    sel_pa;
    logic    wr_a;
    logic    wr_b;
    logic    front_rd;
    logic    load_out;
    logic    set_status;
    status_t code;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    op_t  op;
    logic empty;
    logic full;
    logic short_fill;
    logic last;
    logic hit;
    logic out_free;
  } sts_t;

endpackage

[design/cfsr_ctrl.sv]
module cfsr_ctrl
  import cfsr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.code   = ST_OK;
    in_stall   = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        cmd.set_status = 1'b1;
        state_next     = S_FRONT;
        unique case (sts.op)
          OP_PUSH: begin
            if (sts.full) begin
              cmd.code = ST_OVERFLOW;
            end else begin
              cmd.push = 1'b1;
            end
          end
          OP_POP: begin
            if (sts.empty) begin
              cmd.code = ST_EMPTY;
            end else begin
              cmd.pop = 1'b1;
            end
          end
          OP_CLEAR: begin
            cmd.clear = 1'b1;
          end
          OP_REVERSE: begin
            if (sts.empty) begin
              cmd.code = ST_EMPTY;
            end else begin
              cmd.rev_init = 1'b1;
              if (!sts.short_fill) begin
                state_next = S_REV_RD;
              end
            end
          end
          OP_FIND: begin
            cmd.code      = ST_NOT_FOUND;
            cmd.find_init = 1'b1;
            if (!sts.empty) begin
              state_next = S_FIND_RD;
            end
          end
          default: begin
            cmd.code = ST_OK;
          end
        endcase
      end
      S_REV_RD: begin
        cmd.sel_pa = 1'b1;
        state_next = S_REV_WA;
      end
      S_REV_WA: begin
        // keep the read port on pa so the old front word survives
        cmd.sel_pa = 1'b1;
        cmd.wr_a   = 1'b1;
        state_next = S_REV_WB;
      end
      S_REV_WB: begin
        cmd.wr_b     = 1'b1;
        cmd.rev_step = 1'b1;
        state_next   = sts.last ? S_FRONT : S_REV_RD;
      end
      S_FIND_RD: begin
        cmd.sel_pa = 1'b1;
        state_next = S_FIND_CMP;
      end
      S_FIND_CMP: begin
        if (sts.hit) begin
          cmd.find_hit   = 1'b1;
          cmd.set_status = 1'b1;
          cmd.code       = ST_OK;
          state_next     = S_FRONT;
        end else begin
          cmd.find_step = 1'b1;
          state_next    = sts.last ? S_FRONT : S_FIND_RD;
        end
      end
      S_FRONT: begin
        cmd.front_rd = 1'b1;
        state_next   = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[design/cfsr_dpath.sv]
module cfsr_dpath
  import cfsr_pkg::*;
#(
  parameter int DEPTH = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [2:0]         op,
  input  logic signed [31:0] value,
  input  logic               out_stall,
  input  cmd_t               cmd,
  output sts_t               sts,
  output logic               out_valid,
  output logic [1:0]         status,
  output logic signed [31:0] popped_value,
  output logic [7:0]         position,
  output logic signed [31:0] front_value,
  output logic [7:0]         occupancy
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd_a;
  logic signed [31:0] rd_b;

  op_t                op_q;
  logic signed [31:0] value_q;
  logic [AW-1:0]      head;
  logic [AW-1:0]      tail;
  logic [CW-1:0]      count;
  logic [AW-1:0]      pa;
  logic [AW-1:0]      pb;
  logic [CW-1:0]      left;
  logic [CW-1:0]      pos;
  logic [CW-1:0]      res_pos;
  status_t            status_q;
  logic signed [31:0] popped_q;

  logic               mem_we;
  logic [AW-1:0]      wr_addr;
  logic signed [31:0] wr_data;
  logic [AW-1:0]      addr_a;
  logic [AW:0]        last_sum;
  logic [AW:0]        last_wrap;
  logic [AW-1:0]      last_idx;

  function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] i);
    return (i == AW'(DEPTH - 1)) ? '0 : i + AW'(1);
  endfunction

  function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] i);
    return (i == '0) ? AW'(DEPTH - 1) : i - AW'(1);
  endfunction

  // slot of the newest word
  assign last_sum  = {1'b0, head} + (AW+1)'(count - CW'(1));
  assign last_wrap = (last_sum >= (AW+1)'(DEPTH)) ? last_sum - (AW+1)'(DEPTH) : last_sum;
  assign last_idx  = last_wrap[AW-1:0];

  always_comb begin
    mem_we = cmd.push | cmd.wr_a | cmd.wr_b;
    priority if (cmd.push) begin
      wr_addr = tail;
      wr_data = value_q;
    end else if (cmd.wr_a) begin
      wr_addr = pa;
      wr_data = rd_b;
    end else begin
      wr_addr = pb;
      wr_data = rd_a;
    end
  end

  assign addr_a = cmd.sel_pa ? pa : head;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a <= mem[addr_a];
    rd_b <= mem[pb];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else if (cmd.clear) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else if (cmd.push) begin
      tail  <= idx_inc(tail);
      count <= count + CW'(1);
    end else if (cmd.pop) begin
      head  <= idx_inc(head);
      count <= count - CW'(1);
    end
  end

  // item, walk pointers and result fields
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q    <= op_t'(op);
      value_q <= value;
      res_pos <= '0;
    end
    if (cmd.rev_init) begin
      pa   <= head;
      pb   <= last_idx;
      left <= count >> 1;
    end else if (cmd.find_init) begin
      pa   <= head;
      left <= count;
      pos  <= CW'(1);
    end else if (cmd.rev_step) begin
      pa   <= idx_inc(pa);
      pb   <= idx_dec(pb);
      left <= left - CW'(1);
    end else if (cmd.find_step) begin
      pa   <= idx_inc(pa);
      pos  <= pos + CW'(1);
      left <= left - CW'(1);
    end
    if (cmd.find_hit) begin
      res_pos <= pos;
    end
    if (cmd.set_status) begin
      status_q <= cmd.code;
    end
    if (cmd.front_rd) begin
      popped_q <= (op_q == OP_POP && status_q == ST_OK) ? rd_a : '0;
    end
    if (cmd.load_out) begin
      status       <= status_q;
      popped_value <= popped_q;
      position     <= 8'(res_pos);
      front_value  <= (count != '0) ? rd_a : '0;
      occupancy    <= 8'(count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    sts.op         = op_q;
    sts.empty      = (count == '0);
    sts.full       = (count == CW'(DEPTH));
    sts.short_fill = (count < CW'(2));
    sts.last       = (left == CW'(1));
    sts.hit        = (rd_a == value_q);
    sts.out_free   = !out_valid || !out_stall;
  end

endmodule

[design/circular_fifo_with_search_reverse.sv]
// ring-buffer fifo of 32-bit signed words with in-place reverse and search
//
// input channel (in_valid / in_stall): one op per transfer with its value;
//   op is push, pop, clear, reverse or find
// output channel (out_valid / out_stall): exactly one result per op with
//   status, popped word, match position, front word and occupancy after it
// push, pop, clear and unknown ops pass through the start, front and done
//   states; the result is loaded into the output register from done
// reverse swaps floor(n/2) pairs; each swap reads both ends, then writes
//   them in turn through the single write port
// find examines entries up to the first match, with one read of the ring
//   memory and one compare for each
// one item is in work at a time; in_stall is high from the transfer until
//   the result is loaded into the output register
// a result held by out_stall does not block the next input transfer; only
//   the following result waits for the output register to empty
// reset clears head, tail, count and the output valid; the ring memory is
//   not cleared and needs no clearing pass
module circular_fifo_with_search_reverse
  import cfsr_pkg::*;
#(
  parameter int DEPTH = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         op,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic signed [31:0] popped_value,
  output logic [7:0]         position,
  output logic signed [31:0] front_value,
  output logic [7:0]         occupancy
);

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: one op at a time, walks the ring for reverse and find
  cfsr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // ring memory, pointers, walk counters and output register
  cfsr_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .op           (op),
    .value        (value),
    .out_stall    (out_stall),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (out_valid),
    .status       (status),
    .popped_value (popped_value),
    .position     (position),
    .front_value  (front_value),
    .occupancy    (occupancy)
  );

endmodule

[design/cfsr_checker.sv]
module cfsr_checker
  import cfsr_pkg::*;
#(
  parameter int DEPTH = 128
) (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic [2:0]         op,
  input logic signed [31:0] value,
  input logic               out_valid,
  input logic               out_stall,
  input logic [1:0]         status,
  input logic signed [31:0] popped_value,
  input logic [7:0]         position,
  input logic signed [31:0] front_value,
  input logic [7:0]         occupancy
);

  // one item in work: a transfer closes the input for the next cycle
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in work");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(front_value))
    else $error("stalled result changed");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OVERFLOW |-> occupancy == 8'(DEPTH))
    else $error("overflow reported while not full");

  a_empty_front: assert property (@(posedge clk) disable iff (rst)
    out_valid && occupancy == 8'd0 && DEPTH < 256 |-> front_value == 32'sd0)
    else $error("front word nonzero while empty");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EMPTY |-> popped_value == 32'sd0 && position == 8'd0
      && occupancy == 8'd0)
    else $error("empty status with stale fields");

endmodule

bind circular_fifo_with_search_reverse cfsr_checker #(.DEPTH(DEPTH)) u_cfsr_checker (.*);
